// ===== src/rpst_pkg.sv =====
// Package for the receive pipe sequence table: sizes, codes, item and control types.
// Used by the config interface, the table, the controller, the top level and the checker.
package rpst_pkg;

  localparam int PIPES_DEF    = 8;
  localparam int SEQ_BITS_DEF = 5;

  localparam int PORT_W     = 9;
  localparam int SLOT_FW    = 3;
  localparam int ACT_W      = 3;
  localparam int DEV_W      = 64;
  localparam int SVC_W      = 8;
  localparam int CMD_W      = 16;
  localparam int PORT_SHIFT = 7;
  localparam int CLOSE_BIT  = 5;
  localparam int META_BIT   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    OP_OPEN   = 2'd0,
    OP_PACKET = 2'd1,
    OP_CLOSE  = 2'd2
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_IGNORED = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_META    = 3'd2,
    ACT_EOF     = 3'd3,
    ACT_OPENED  = 3'd4,
    ACT_REFUSED = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_DEVICE_ID = 2'd0,
    CFG_STREAM_SVC    = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN,
    ST_EOF
  } state_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SLOT_FW-1:0] slot;
    logic [PORT_W-1:0]  proposed_port;
    logic [SVC_W-1:0]   svc_idx;
    logic               is_report;
    logic [DEV_W-1:0]   device_id;
    logic [CMD_W-1:0]   command;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SLOT_FW-1:0] result_slot;
    logic [PORT_W-1:0]  result_port;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic valid_we;
    logic valid_val;
    logic data_we;
  } tbl_wr_t;

endpackage

// ===== src/rpst_stream_if.sv =====
// Valid/ready stream channel carrying one item type per transaction.
// Depends on nothing; the payload type comes in as a type parameter.
interface rpst_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/rpst_cfg_if.sv =====
// Configuration write channel: register index and write data with valid/ready.
// Depends on rpst_pkg for the field widths.
interface rpst_cfg_if
  import rpst_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/rpst_table.sv =====
// Slot table: valid flags in flip-flops, port and sequence in a memory with registered read.
// Depends on rpst_pkg for the write control type and port width.
module rpst_table
  import rpst_pkg::*;
#(
  parameter int PIPES    = PIPES_DEF,
  parameter int SEQ_BITS = SEQ_BITS_DEF,
  localparam int SLOT_W  = (PIPES > 1) ? $clog2(PIPES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SLOT_W-1:0]   rd_idx_i,
  output logic                rd_valid_o,
  output logic [PORT_W-1:0]   rd_port_o,
  output logic [SEQ_BITS-1:0] rd_seq_o,
  input  tbl_wr_t             wr_i,
  input  logic [SLOT_W-1:0]   wr_idx_i,
  input  logic [PORT_W-1:0]   wr_port_i,
  input  logic [SEQ_BITS-1:0] wr_seq_i
);

  logic [PIPES-1:0]    valid_q;
  logic                rd_valid_q;
  logic [PORT_W-1:0]   port_mem [PIPES];
  logic [SEQ_BITS-1:0] seq_mem  [PIPES];
  logic [PORT_W-1:0]   rd_port_q;
  logic [SEQ_BITS-1:0] rd_seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.valid_we) begin
        valid_q[wr_idx_i] <= wr_i.valid_val;
      end
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.data_we) begin
      port_mem[wr_idx_i] <= wr_port_i;
      seq_mem[wr_idx_i]  <= wr_seq_i;
    end else if (wr_i.valid_we && wr_i.valid_val) begin
      port_mem[wr_idx_i] <= wr_port_i;
    end
    rd_port_q <= port_mem[rd_idx_i];
    rd_seq_q  <= seq_mem[rd_idx_i];
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_port_o  = rd_port_q;
  assign rd_seq_o   = rd_seq_q;

endmodule

// ===== src/rpst_ctrl.sv =====
// Sequencer: latches a transaction, scans the slots through one port comparator,
// then writes the table and loads the result register. Depends on rpst_pkg.
module rpst_ctrl
  import rpst_pkg::*;
#(
  parameter int PIPES    = PIPES_DEF,
  parameter int SEQ_BITS = SEQ_BITS_DEF,
  localparam int SLOT_W  = (PIPES > 1) ? $clog2(PIPES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DEV_W-1:0]    own_id_i,
  input  logic [SVC_W-1:0]    svc_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  output logic [SLOT_W-1:0]   rd_idx_o,
  input  logic                rd_valid_i,
  input  logic [PORT_W-1:0]   rd_port_i,
  input  logic [SEQ_BITS-1:0] rd_seq_i,
  output tbl_wr_t             wr_o,
  output logic [SLOT_W-1:0]   wr_idx_o,
  output logic [PORT_W-1:0]   wr_port_o,
  output logic [SEQ_BITS-1:0] wr_seq_o
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(PIPES - 1);

  state_e              state_q, state_d;
  logic [1:0]          op_q;
  logic [SLOT_FW-1:0]  s_q;
  logic [PORT_W-1:0]   key_q;
  logic                meta_q, close_q, addr_q;
  logic [SEQ_BITS-1:0] seq_in_q;
  logic [SLOT_W-1:0]   idx_q;
  logic                cmp_vld_q;
  logic [SLOT_W-1:0]   cmp_idx_q;
  logic                found_q;
  logic [SLOT_W-1:0]   hit_idx_q;
  logic [SEQ_BITS-1:0] hit_seq_q;
  logic                out_vld_q, out_vld_d;
  out_item_t           out_q, out_d;

  logic                accept, hit, out_free, load, s_ok;
  logic [SLOT_W-1:0]   s_idx;
  logic [SLOT_FW-1:0]  hit_slot;
  logic [ACT_W-1:0]    data_act;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;
  assign s_idx    = SLOT_W'(s_q);
  assign s_ok     = 32'(s_q) < 32'(PIPES);
  assign hit_slot = SLOT_FW'(hit_idx_q);
  assign data_act = meta_q ? ACT_META : ACT_DATA;
  assign rd_idx_o = idx_q;

  assign hit = cmp_vld_q && rd_valid_i && (rd_port_i == key_q) &&
               !((op_q == OP_OPEN) && (cmp_idx_q == s_idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      out_vld_q <= out_vld_d;
      if (accept) begin
        found_q <= 1'b0;
      end else if (hit && !found_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (accept) begin
      op_q     <= in_data_i.opcode;
      s_q      <= in_data_i.slot;
      key_q    <= (in_data_i.opcode == OP_OPEN) ? in_data_i.proposed_port :
                  in_data_i.command[PORT_SHIFT +: PORT_W];
      meta_q   <= in_data_i.command[META_BIT];
      close_q  <= in_data_i.command[CLOSE_BIT];
      seq_in_q <= in_data_i.command[SEQ_BITS-1:0];
      addr_q   <= (in_data_i.svc_idx == svc_i) && !in_data_i.is_report &&
                  (in_data_i.device_id == own_id_i);
      idx_q    <= '0;
    end else if (state_q == ST_SCAN) begin
      idx_q <= idx_q + 1'b1;
    end
    if (hit && !found_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_seq_q <= rd_seq_i;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    load       = 1'b0;
    out_d      = '{action: ACT_IGNORED, result_slot: '0, result_port: '0, last: 1'b1};
    wr_o       = '0;
    wr_idx_o   = s_idx;
    wr_port_o  = key_q;
    wr_seq_o   = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
          case (op_q)
            OP_OPEN: begin
              if (!s_ok) begin
                out_d = '{action: ACT_REFUSED, result_slot: '0, result_port: key_q,
                          last: 1'b1};
              end else if ((key_q == '0) || found_q) begin
                out_d = '{action: ACT_REFUSED, result_slot: s_q, result_port: key_q,
                          last: 1'b1};
                wr_o.valid_we = 1'b1;
              end else begin
                out_d = '{action: ACT_OPENED, result_slot: s_q, result_port: key_q,
                          last: 1'b1};
                wr_o = '{valid_we: 1'b1, valid_val: 1'b1, data_we: 1'b1};
              end
            end
            OP_CLOSE: begin
              if (s_ok) begin
                out_d.result_slot = s_q;
                wr_o.valid_we     = 1'b1;
              end
            end
            OP_PACKET: begin
              wr_idx_o = hit_idx_q;
              wr_port_o = key_q;
              if (addr_q && found_q) begin
                out_d.result_slot = hit_slot;
                out_d.result_port = key_q;
                if (hit_seq_q == seq_in_q) begin
                  wr_o.data_we  = 1'b1;
                  wr_seq_o      = hit_seq_q + 1'b1;
                  out_d.action  = data_act;
                  if (close_q) begin
                    out_d.last    = 1'b0;
                    wr_o.valid_we = 1'b1;
                    state_d       = ST_EOF;
                  end
                end
              end
            end
            default: begin
              out_d.last = 1'b1;
            end
          endcase
        end
      end
      ST_EOF: begin
        if (out_free) begin
          load    = 1'b1;
          out_d   = '{action: ACT_EOF, result_slot: hit_slot, result_port: key_q,
                      last: 1'b1};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/pipe_receive_sequence_table_unit.sv =====
// Receive pipe sequence table top level: config registers, slot table, sequencer.
// The port scan covers one slot per cycle; a new input transaction is accepted only
// after the previous one has loaded its last result into the output register.
// A delivered packet with a close flag adds a second, end-of-file result. Reset
// clears all slot valid flags, config and handshake state.
// Depends on rpst_pkg, rpst_stream_if, rpst_cfg_if, rpst_table and rpst_ctrl.
module pipe_receive_sequence_table_unit
  import rpst_pkg::*;
#(
  parameter int PIPES    = PIPES_DEF,
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rpst_cfg_if.sink cfg_i,
  rpst_stream_if.sink in_i,
  rpst_stream_if.source out_o
);

  localparam int SLOT_W = (PIPES > 1) ? $clog2(PIPES) : 1;

  logic [DEV_W-1:0]    own_id_q;
  logic [SVC_W-1:0]    svc_q;
  logic [SLOT_W-1:0]   rd_idx, wr_idx;
  logic                rd_valid;
  logic [PORT_W-1:0]   rd_port, wr_port;
  logic [SEQ_BITS-1:0] rd_seq, wr_seq;
  tbl_wr_t             wr;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      svc_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_OWN_DEVICE_ID: own_id_q <= cfg_i.data;
        CFG_STREAM_SVC:    svc_q    <= cfg_i.data[SVC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpst_table #(
    .PIPES    (PIPES),
    .SEQ_BITS (SEQ_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_valid_o (rd_valid),
    .rd_port_o  (rd_port),
    .rd_seq_o   (rd_seq),
    .wr_i       (wr),
    .wr_idx_i   (wr_idx),
    .wr_port_i  (wr_port),
    .wr_seq_i   (wr_seq)
  );

  rpst_ctrl #(
    .PIPES    (PIPES),
    .SEQ_BITS (SEQ_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .own_id_i    (own_id_q),
    .svc_i       (svc_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data),
    .rd_idx_o    (rd_idx),
    .rd_valid_i  (rd_valid),
    .rd_port_i   (rd_port),
    .rd_seq_i    (rd_seq),
    .wr_o        (wr),
    .wr_idx_o    (wr_idx),
    .wr_port_o   (wr_port),
    .wr_seq_o    (wr_seq)
  );

endmodule

// ===== src/rpst_checker.sv =====
// Port-level checker for the receive pipe sequence table, bound to the top level.
// Depends on rpst_pkg for the item types and action codes.
module rpst_checker
  import rpst_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after a transaction");

  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.last |->
      (out_data_i.action == ACT_DATA) || (out_data_i.action == ACT_META))
    else $error("non-final result is not a delivery");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.action == ACT_EOF) |-> out_data_i.last)
    else $error("end of file not final");

  a_open_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.action == ACT_OPENED) |-> (out_data_i.result_port != '0))
    else $error("opened at port zero");

endmodule

bind pipe_receive_sequence_table_unit rpst_checker u_rpst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
